@@ sv/u8r_pkg.sv @@
package u8r_pkg;

  typedef logic [7:0] byte_val_t;
  typedef logic [2:0] count_t;
  typedef logic [1:0] held_idx_t;

  localparam int unsigned HELD_DEPTH = 3;

  localparam byte_val_t ASCII_LIMIT = 8'h80;
  localparam byte_val_t LEAD2_LO    = 8'hC2;
  localparam byte_val_t LEAD2_HI    = 8'hDF;
  localparam byte_val_t LEAD3_LO    = 8'hE0;
  localparam byte_val_t LEAD3_HI    = 8'hEF;
  localparam byte_val_t LEAD4_LO    = 8'hF0;
  localparam byte_val_t LEAD4_HI    = 8'hF4;
  localparam byte_val_t CONT_MASK   = 8'hC0;
  localparam byte_val_t CONT_TAG    = 8'h80;
  localparam byte_val_t REPL_B0     = 8'hEF;
  localparam byte_val_t REPL_B1     = 8'hBF;
  localparam byte_val_t REPL_B2     = 8'hBD;

  localparam count_t LEN_NONE = 3'd0;
  localparam count_t LEN_ONE  = 3'd1;
  localparam count_t LEN_TWO  = 3'd2;
  localparam count_t LEN_THR  = 3'd3;
  localparam count_t LEN_FOUR = 3'd4;

  function automatic logic is_cont(input byte_val_t b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

@@ sv/u8r_if.sv @@
interface u8r_in_if
  import u8r_pkg::*;
;
  logic      valid;
  logic      ready;
  byte_val_t in_byte;
  logic      piece_last;

  modport source (output valid, output in_byte, output piece_last, input ready);
  modport sink   (input valid, input in_byte, input piece_last, output ready);
endinterface

interface u8r_out_if
  import u8r_pkg::*;
;
  logic      valid;
  logic      ready;
  count_t    out_count;
  byte_val_t out_byte0;
  byte_val_t out_byte1;
  byte_val_t out_byte2;
  byte_val_t out_byte3;
  logic      piece_done;

  modport source (output valid, output out_count, output out_byte0, output out_byte1,
                  output out_byte2, output out_byte3, output piece_done, input ready);
  modport sink   (input valid, input out_count, input out_byte0, input out_byte1,
                  input out_byte2, input out_byte3, input piece_done, output ready);
endinterface

@@ sv/utf8_stream_reassembler_unit.sv @@
// UTF-8 stream reassembler: one byte is taken per transfer and exactly one
// result leaves for each byte, in order. ASCII passes through as a one byte
// result; lead bytes C2-DF, E0-EF, F0-F4 open a 2, 3 or 4 byte sequence that
// is held (results with count 0) until its last byte arrives, and the whole
// sequence then leaves in one result, or EF BF BD if a trailing byte is not
// 10xxxxxx. Stray bytes with nothing pending give EF BF BD. A lead byte inside
// a sequence is taken as a bad continuation. piece_last is echoed as
// piece_done and never flushes a pending sequence. The result appears in the
// cycle after its byte is taken and a new byte is taken every cycle; the only
// limit is the single output register, which accepts a byte whenever it is
// empty or its result is being taken in the same cycle.
module utf8_stream_reassembler_unit
  import u8r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8r_in_if.sink    in_ch,
  u8r_out_if.source out_ch
);

  byte_val_t held_r [HELD_DEPTH];
  count_t    seq_len_r, seq_len_nxt;
  held_idx_t held_cnt_r, held_cnt_nxt;

  logic      out_valid_r;
  count_t    out_count_r, out_count_nxt;
  byte_val_t out_b0_r, out_b0_nxt;
  byte_val_t out_b1_r, out_b1_nxt;
  byte_val_t out_b2_r, out_b2_nxt;
  byte_val_t out_b3_r, out_b3_nxt;
  logic      out_done_r;

  logic      in_fire;
  logic      held_wr;
  logic      complete;
  logic      seq_ok;
  byte_val_t b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign complete    = ({1'b0, held_cnt_r} + LEN_ONE) >= seq_len_r;
  assign seq_ok      = is_cont(b)
                       && (seq_len_r < LEN_THR  || is_cont(held_r[1]))
                       && (seq_len_r < LEN_FOUR || is_cont(held_r[2]));

  always_comb begin
    seq_len_nxt   = seq_len_r;
    held_cnt_nxt  = held_cnt_r;
    held_wr       = 1'b0;
    out_count_nxt = LEN_NONE;
    out_b0_nxt    = '0;
    out_b1_nxt    = '0;
    out_b2_nxt    = '0;
    out_b3_nxt    = '0;
    if (seq_len_r == LEN_NONE) begin
      priority if (b < ASCII_LIMIT) begin
        out_count_nxt = LEN_ONE;
        out_b0_nxt    = b;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        seq_len_nxt = LEN_TWO;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        seq_len_nxt = LEN_THR;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        seq_len_nxt = LEN_FOUR;
      end else begin
        out_count_nxt = LEN_THR;
        out_b0_nxt    = REPL_B0;
        out_b1_nxt    = REPL_B1;
        out_b2_nxt    = REPL_B2;
      end
      if (seq_len_nxt != LEN_NONE) begin
        held_wr      = 1'b1;
        held_cnt_nxt = 2'd1;
      end
    end else if (complete) begin
      seq_len_nxt  = LEN_NONE;
      held_cnt_nxt = '0;
      if (seq_ok) begin
        out_count_nxt = seq_len_r;
        out_b0_nxt    = held_r[0];
        unique case (seq_len_r)
          LEN_TWO: begin
            out_b1_nxt = b;
          end
          LEN_THR: begin
            out_b1_nxt = held_r[1];
            out_b2_nxt = b;
          end
          LEN_FOUR: begin
            out_b1_nxt = held_r[1];
            out_b2_nxt = held_r[2];
            out_b3_nxt = b;
          end
          default: begin
            out_count_nxt = LEN_NONE;
            out_b0_nxt    = '0;
          end
        endcase
      end else begin
        out_count_nxt = LEN_THR;
        out_b0_nxt    = REPL_B0;
        out_b1_nxt    = REPL_B1;
        out_b2_nxt    = REPL_B2;
      end
    end else begin
      held_wr      = 1'b1;
      held_cnt_nxt = held_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r   <= LEN_NONE;
      held_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        seq_len_r   <= seq_len_nxt;
        held_cnt_r  <= held_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_count_r <= out_count_nxt;
      out_b0_r    <= out_b0_nxt;
      out_b1_r    <= out_b1_nxt;
      out_b2_r    <= out_b2_nxt;
      out_b3_r    <= out_b3_nxt;
      out_done_r  <= in_ch.piece_last;
      if (held_wr) begin
        held_r[held_cnt_r] <= b;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_count  = out_count_r;
  assign out_ch.out_byte0  = out_b0_r;
  assign out_ch.out_byte1  = out_b1_r;
  assign out_ch.out_byte2  = out_b2_r;
  assign out_ch.out_byte3  = out_b3_r;
  assign out_ch.piece_done = out_done_r;

  a_pending_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_len_r == LEN_NONE) == (held_cnt_r == '0))
    else $error("held count disagrees with pending sequence");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r == LEN_NONE || seq_len_r == LEN_TWO
    || seq_len_r == LEN_THR || seq_len_r == LEN_FOUR)
    else $error("illegal sequence length");

  a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && seq_len_r == LEN_NONE && b < ASCII_LIMIT
    |=> out_ch.valid && out_ch.out_count == LEN_ONE)
    else $error("ascii byte not passed through");

  a_empty_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_count_r == LEN_NONE |-> seq_len_r != LEN_NONE)
    else $error("empty result without a pending sequence");

endmodule
